// ===== hw/rtl/c3w_pkg.sv =====
`default_nettype none

package c3w_pkg;

   localparam int COORD_W   = 9;
   localparam int SIZE_W    = 10;
   localparam int PIX_W     = 8;
   localparam int COEFF_W   = 7;
   localparam int KERNEL_N  = 9;
   localparam int KCOEF_W   = COEFF_W * KERNEL_N;
   localparam int SHIFT_W   = 3;
   localparam int PROD_W    = PIX_W + 1 + COEFF_W;
   localparam int ACC_W     = 19;
   localparam int TAP_W     = 2;
   localparam int MODCNT_W  = 4;

   localparam logic [TAP_W-1:0]    TAP_LAST      = 2'd2;
   localparam logic [MODCNT_W-1:0] MOD_LAST_STEP = 4'(COORD_W - 1);
   localparam logic [PIX_W-1:0]    PIXEL_MAX     = 8'd255;

   localparam logic [SIZE_W-1:0]  ROWS_RESET   = 10'd512;
   localparam logic [SIZE_W-1:0]  COLS_RESET   = 10'd512;
   localparam logic [KCOEF_W-1:0] KCOEF_RESET  = 63'd268435456;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET  = 3'd0;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ROWS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COLS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_COEFFS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_SHIFT   = 2'd3;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_READ,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [SIZE_W-1:0]  frame_rows;
      logic [SIZE_W-1:0]  frame_cols;
      logic [KCOEF_W-1:0] kernel_coeffs;
      logic [SHIFT_W-1:0] coeff_shift;
   } csr_type;

   typedef struct packed {
      logic             load_wr;
      logic             mod_start;
      logic             mod_step;
      logic             rd_issue;
      logic [TAP_W-1:0] tap_i;
      logic [TAP_W-1:0] tap_j;
      logic             out_load;
   } cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic out_full;
   } status_type;

   // coefficient (i,j) sits at bits COEFF_W*(3i+j) upward
   function automatic logic signed [COEFF_W-1:0] coeff_at(
      input logic [KCOEF_W-1:0] coeffs,
      input logic [TAP_W-1:0]   i,
      input logic [TAP_W-1:0]   j
   );
      logic [3:0]                 idx;
      logic signed [COEFF_W-1:0]  c;
      idx = 4'(i) * 4'd3 + 4'(j);
      c   = '0;
      for (int n = 0; n < KERNEL_N; n++) begin
         if (4'(n) == idx) begin
            c = $signed(coeffs[COEFF_W*n +: COEFF_W]);
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/conv3x3_clamped_wrap_unit.sv =====
`default_nettype none

// 3x3 convolution over a greyscale frame held in an on-chip memory of
// 2^(clog2(MAX_ROWS)+clog2(MAX_COLS)) bytes. A load request (operation 0) writes one
// pixel and gives no response; the next request is taken the
// following cycle. A compute request (operation 1) returns one clamped pixel with its
// row and column echoed. It occupies the block through the bit-serial modulo of row and
// column by the frame size, the neighbor reads through the single memory read port, the
// drain of the multiply and accumulate pipeline and the load of the output register; no
// further request is taken until it is done, and the output load waits while an earlier
// response is still held. A finished result waits in an output register while further
// requests are accepted. Pixels never loaded since reset read as unknown. Write the
// configuration registers only while no compute request is outstanding.
module conv3x3_clamped_wrap_unit #(
   parameter int MAX_ROWS = 512,
   parameter int MAX_COLS = 512
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  wire                            req_operation,
   input  wire [c3w_pkg::COORD_W-1:0]     req_row,
   input  wire [c3w_pkg::COORD_W-1:0]     req_col,
   input  wire [c3w_pkg::PIX_W-1:0]       req_pixel_in,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic [c3w_pkg::PIX_W-1:0]      rsp_result_pixel,
   output logic [c3w_pkg::COORD_W-1:0]    rsp_result_row,
   output logic [c3w_pkg::COORD_W-1:0]    rsp_result_col,
   input  wire                            csr_wr_en,
   input  wire [c3w_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [c3w_pkg::KCOEF_W-1:0]     csr_wdata
);
   import c3w_pkg::*;

   csr_type    csr_ff, csr_in;
   cmd_type    cmd;
   status_type status;

   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_ROWS:    csr_in.frame_rows    = csr_wdata[SIZE_W-1:0];
            CSR_FRAME_COLS:    csr_in.frame_cols    = csr_wdata[SIZE_W-1:0];
            CSR_KERNEL_COEFFS: csr_in.kernel_coeffs = csr_wdata;
            CSR_COEFF_SHIFT:   csr_in.coeff_shift   = csr_wdata[SHIFT_W-1:0];
            default: begin
               csr_in = csr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.frame_rows    <= ROWS_RESET;
         csr_ff.frame_cols    <= COLS_RESET;
         csr_ff.kernel_coeffs <= KCOEF_RESET;
         csr_ff.coeff_shift   <= SHIFT_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   c3w_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .rsp_ready     (rsp_ready),
      .status        (status),
      .cmd           (cmd)
   );

   c3w_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr              (csr_ff),
      .cmd              (cmd),
      .status           (status),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_pixel_in     (req_pixel_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_pixel (rsp_result_pixel),
      .rsp_result_row   (rsp_result_row),
      .rsp_result_col   (rsp_result_col)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/c3w_divmod.sv =====
`default_nettype none

// Restoring remainder: one dividend bit per step, COORD_W steps after start.
module c3w_divmod (
   input  wire                          clock,
   input  wire                          start,
   input  wire                          step,
   input  wire [c3w_pkg::COORD_W-1:0]   dividend,
   input  wire [c3w_pkg::SIZE_W-1:0]    divisor,
   output logic [c3w_pkg::SIZE_W-1:0]   remainder
);
   import c3w_pkg::*;

   logic [SIZE_W-1:0]  rem_ff, rem_in;
   logic [COORD_W-1:0] dvd_ff, dvd_in;
   logic [SIZE_W:0]    trial;

   always_comb begin
      trial  = {rem_ff, dvd_ff[COORD_W-1]};
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      if (start) begin
         rem_in = '0;
         dvd_in = dividend;
      end else if (step) begin
         dvd_in = dvd_ff << 1;
         if (trial >= {1'b0, divisor}) begin
            rem_in = SIZE_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[SIZE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/c3w_ctrl.sv =====
`default_nettype none

module c3w_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire                   req_operation,
   input  wire                   rsp_ready,
   input  c3w_pkg::status_type   status,
   output c3w_pkg::cmd_type      cmd
);
   import c3w_pkg::*;

   state_type            state_ff, state_in;
   logic [MODCNT_W-1:0]  mod_cnt_ff, mod_cnt_in;
   logic [TAP_W-1:0]     tap_i_ff, tap_i_in;
   logic [TAP_W-1:0]     tap_j_ff, tap_j_in;
   logic                 out_free;
   logic                 taps_done;

   assign out_free  = !status.out_full || rsp_ready;
   assign taps_done = (tap_i_ff == TAP_LAST) && (tap_j_ff == TAP_LAST);

   // next state and counters
   always_comb begin
      state_in   = state_ff;
      mod_cnt_in = mod_cnt_ff;
      tap_i_in   = tap_i_ff;
      tap_j_in   = tap_j_ff;
      case (state_ff)
         ST_IDLE: begin
            mod_cnt_in = '0;
            if (req_valid && req_operation == OP_COMPUTE) begin
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            mod_cnt_in = mod_cnt_ff + 1'b1;
            if (mod_cnt_ff == MOD_LAST_STEP) begin
               state_in = ST_READ;
               tap_i_in = '0;
               tap_j_in = '0;
            end
         end
         ST_READ: begin
            if (tap_j_ff == TAP_LAST) begin
               tap_j_in = '0;
               tap_i_in = tap_i_ff + 1'b1;
            end else begin
               tap_j_in = tap_j_ff + 1'b1;
            end
            if (taps_done) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.tap_i     = tap_i_ff;
      cmd.tap_j     = tap_j_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_wr   = req_valid && (req_operation == OP_LOAD);
            cmd.mod_start = req_valid && (req_operation == OP_COMPUTE);
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
         end
         ST_DRAIN: begin
            cmd.rd_issue = 1'b0;
         end
         ST_FINISH: begin
            cmd.out_load = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         mod_cnt_ff <= '0;
         tap_i_ff   <= '0;
         tap_j_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         mod_cnt_ff <= mod_cnt_in;
         tap_i_ff   <= tap_i_in;
         tap_j_ff   <= tap_j_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/c3w_datapath.sv =====
`default_nettype none

module c3w_datapath #(
   parameter int MAX_ROWS = 512,
   parameter int MAX_COLS = 512
) (
   input  wire                          clock,
   input  wire                          reset,
   input  c3w_pkg::csr_type             csr,
   input  c3w_pkg::cmd_type             cmd,
   output c3w_pkg::status_type          status,
   input  wire [c3w_pkg::COORD_W-1:0]   req_row,
   input  wire [c3w_pkg::COORD_W-1:0]   req_col,
   input  wire [c3w_pkg::PIX_W-1:0]     req_pixel_in,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [c3w_pkg::PIX_W-1:0]    rsp_result_pixel,
   output logic [c3w_pkg::COORD_W-1:0]  rsp_result_row,
   output logic [c3w_pkg::COORD_W-1:0]  rsp_result_col
);
   import c3w_pkg::*;

   localparam int RW        = $clog2(MAX_ROWS);
   localparam int CW        = $clog2(MAX_COLS);
   localparam int MEM_DEPTH = 1 << (RW + CW);

   function automatic logic [SIZE_W-1:0] wrap_add(
      input logic [SIZE_W-1:0] base,
      input logic [TAP_W-1:0]  offs,
      input logic [SIZE_W-1:0] size
   );
      logic [SIZE_W:0] v;
      v = (SIZE_W+1)'(base) + (SIZE_W+1)'(offs);
      if (v >= {1'b0, size}) begin
         v = v - {1'b0, size};
      end
      if (v >= {1'b0, size}) begin
         v = v - {1'b0, size};
      end
      return v[SIZE_W-1:0];
   endfunction

   logic [PIX_W-1:0] mem [MEM_DEPTH];

   logic [SIZE_W-1:0]        rows_eff, cols_eff;
   logic [SIZE_W-1:0]        x_rem, y_rem;
   logic [SIZE_W-1:0]        tap_r, tap_c;
   logic [RW+CW-1:0]         wr_addr, rd_addr;
   logic                     load_in_range;

   logic [COORD_W-1:0]       row_ff, col_ff;
   logic [PIX_W-1:0]         rd_data_ff;
   logic                     rd_vld_ff;
   logic [TAP_W-1:0]         tap_i_d1_ff, tap_j_d1_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_vld_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  shifted;
   logic [PIX_W-1:0]         clamped;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]         rsp_pixel_ff;
   logic [COORD_W-1:0]       rsp_row_ff, rsp_col_ff;

   // frame size in use: zero acts as one, oversize acts as the store limit
   always_comb begin
      if (csr.frame_rows == '0) begin
         rows_eff = SIZE_W'(1);
      end else if (32'(csr.frame_rows) > MAX_ROWS) begin
         rows_eff = SIZE_W'(MAX_ROWS);
      end else begin
         rows_eff = csr.frame_rows;
      end
      if (csr.frame_cols == '0) begin
         cols_eff = SIZE_W'(1);
      end else if (32'(csr.frame_cols) > MAX_COLS) begin
         cols_eff = SIZE_W'(MAX_COLS);
      end else begin
         cols_eff = csr.frame_cols;
      end
   end

   c3w_divmod u_row_mod (
      .clock     (clock),
      .start     (cmd.mod_start),
      .step      (cmd.mod_step),
      .dividend  (req_row),
      .divisor   (rows_eff),
      .remainder (x_rem)
   );

   c3w_divmod u_col_mod (
      .clock     (clock),
      .start     (cmd.mod_start),
      .step      (cmd.mod_step),
      .dividend  (req_col),
      .divisor   (cols_eff),
      .remainder (y_rem)
   );

   // neighbor at (x+2-i, y+2-j), wrapped into the frame
   assign tap_r = wrap_add(x_rem, TAP_LAST - cmd.tap_i, rows_eff);
   assign tap_c = wrap_add(y_rem, TAP_LAST - cmd.tap_j, cols_eff);
   assign rd_addr = {RW'(tap_r), CW'(tap_c)};

   assign load_in_range = (32'(req_row) < MAX_ROWS) && (32'(req_col) < MAX_COLS);
   assign wr_addr       = {RW'(req_row), CW'(req_col)};

   always_ff @(posedge clock) begin
      if (cmd.load_wr && load_in_range) begin
         mem[wr_addr] <= req_pixel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign prod_in = $signed({1'b0, rd_data_ff})
                    * coeff_at(csr.kernel_coeffs, tap_i_d1_ff, tap_j_d1_ff);

   always_comb begin
      acc_in = acc_ff;
      if (cmd.mod_start) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   // arithmetic shift floors toward minus infinity
   always_comb begin
      shifted = acc_ff >>> csr.coeff_shift;
      if (shifted < 0) begin
         clamped = '0;
      end else if (shifted > $signed(ACC_W'(PIXEL_MAX))) begin
         clamped = PIXEL_MAX;
      end else begin
         clamped = shifted[PIX_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff    <= cmd.rd_issue;
         prod_vld_ff  <= rd_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tap_i_d1_ff <= cmd.tap_i;
      tap_j_d1_ff <= cmd.tap_j;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      if (cmd.mod_start) begin
         row_ff <= req_row;
         col_ff <= req_col;
      end
      if (cmd.out_load) begin
         rsp_pixel_ff <= clamped;
         rsp_row_ff   <= row_ff;
         rsp_col_ff   <= col_ff;
      end
   end

   assign status.pipe_busy = rd_vld_ff || prod_vld_ff;
   assign status.out_full  = rsp_valid_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_pixel = rsp_pixel_ff;
   assign rsp_result_row   = rsp_row_ff;
   assign rsp_result_col   = rsp_col_ff;

endmodule

`default_nettype wire
